@@ rtl/cwfc_pkg.sv @@
// Package for the CRC-8 word/frame codec: item and result types,
// the queue entry type, CRC constants and the byte-wide CRC function.
// No dependencies.
`default_nettype none

package cwfc_pkg;

  // CRC-8, polynomial x^8 + x^5 + x^4 + 1, restarted for each word
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Frame length limit and widths of the frame counters
  localparam int unsigned MAX_WORDS = 3;
  localparam int unsigned TGT_W     = 2;
  localparam int unsigned WSLOT_W   = 3;
  localparam int unsigned FRAME_W   = 48;

  // Byte position within a three-byte group
  localparam logic [1:0] SLOT_HIGH = 2'd0;
  localparam logic [1:0] SLOT_LOW  = 2'd1;
  localparam logic [1:0] SLOT_CRC  = 2'd2;

  // Request kinds
  localparam logic REQ_DECODE = 1'b0;
  localparam logic REQ_ENCODE = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       frame_start;
    logic [1:0] frame_words;
  } req_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               out_valid;
    logic [15:0]        word_value;
    logic               word_valid;
    logic               crc_ok;
    logic [FRAME_W-1:0] frame_value;
    logic               frame_done;
    logic               frame_ok;
    logic               last;
  } res_t;

  // One queue entry: the first result, and optionally a trailing CRC byte
  typedef struct packed {
    res_t       first;
    logic       two;
    logic [7:0] crc_byte;
  } job_t;

  // CRC update over one byte, MSB first
  function automatic logic [7:0] crc8(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/cwfc_queue.sv @@
// Small FIFO of jobs between the codec front end and the output stage.
// Depends on cwfc_pkg (job_t).
`default_nettype none

module cwfc_queue
  import cwfc_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire job_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output job_t      rd_data,
  output logic      empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/cwfc_front.sv @@
// Front end of the codec: takes bytes, runs the CRC, group and frame
// tracking, and builds jobs for the output stage. Depends on cwfc_pkg.
`default_nettype none

module cwfc_front
  import cwfc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire req_t req,
  output logic      job_push,
  output job_t      job
);

  logic [7:0]         crc_run;
  logic [1:0]         byte_slot;
  logic [WSLOT_W-1:0] word_slot;
  logic [TGT_W-1:0]   words_target;
  logic [7:0]         high_hold;
  logic [7:0]         low_hold;
  logic [FRAME_W-1:0] assembled;
  logic               frame_good;

  logic [7:0]         crc_run_next;
  logic [1:0]         byte_slot_next;
  logic [WSLOT_W-1:0] word_slot_next;
  logic [TGT_W-1:0]   words_target_next;
  logic [7:0]         high_hold_next;
  logic [7:0]         low_hold_next;
  logic [FRAME_W-1:0] assembled_next;
  logic               frame_good_next;

  // State as seen after an optional frame restart
  logic [7:0]         crc_c;
  logic [1:0]         slot_c;
  logic [WSLOT_W-1:0] wslot_c;
  logic [TGT_W-1:0]   tgt_c;
  logic [FRAME_W-1:0] acc_c;
  logic               good_c;
  logic [TGT_W-1:0]   fw_clamped;

  logic [7:0]         crc_upd;
  logic [15:0]        word;
  logic               ok;
  logic               done;
  logic [WSLOT_W-1:0] wslot_inc;
  logic [FRAME_W-1:0] acc_shift;
  logic               first_slot;

  // Frame restart and clamping of the frame length
  always_comb begin
    if (req.frame_words == '0) begin
      fw_clamped = TGT_W'(1);
    end else if ({1'b0, req.frame_words} > 3'(MAX_WORDS)) begin
      fw_clamped = TGT_W'(MAX_WORDS);
    end else begin
      fw_clamped = req.frame_words;
    end
    crc_c   = req.frame_start ? CRC_INIT   : crc_run;
    slot_c  = req.frame_start ? SLOT_HIGH  : byte_slot;
    wslot_c = req.frame_start ? '0         : word_slot;
    tgt_c   = req.frame_start ? fw_clamped : words_target;
    acc_c   = req.frame_start ? '0         : assembled;
    good_c  = req.frame_start ? 1'b1       : frame_good;
  end

  // Datapath pieces shared by the cases below
  always_comb begin
    first_slot = (slot_c == SLOT_HIGH) || (slot_c == 2'd3);
    crc_upd    = crc8(first_slot ? CRC_INIT : crc_c, req.data_byte);
    word       = {high_hold, low_hold};
    ok         = (req.data_byte == crc_c);
    wslot_inc  = wslot_c + 1'b1;
    done       = (wslot_inc >= WSLOT_W'(tgt_c));
    acc_shift  = {acc_c[FRAME_W-17:0], word};
  end

  // Next state and job
  always_comb begin
    crc_run_next      = crc_c;
    byte_slot_next    = slot_c;
    word_slot_next    = wslot_c;
    words_target_next = tgt_c;
    high_hold_next    = high_hold;
    low_hold_next     = low_hold;
    assembled_next    = acc_c;
    frame_good_next   = good_c;
    job_push          = 1'b0;
    job               = '0;

    if (req.req_type == REQ_DECODE) begin
      priority if (first_slot) begin
        crc_run_next   = crc_upd;
        high_hold_next = req.data_byte;
        byte_slot_next = SLOT_LOW;
      end else if (slot_c == SLOT_LOW) begin
        crc_run_next   = crc_upd;
        low_hold_next  = req.data_byte;
        byte_slot_next = SLOT_CRC;
      end else begin
        // CRC byte: report the word
        job_push                = 1'b1;
        job.first.word_value    = word;
        job.first.word_valid    = 1'b1;
        job.first.crc_ok        = ok;
        job.first.frame_value   = acc_shift;
        job.first.frame_done    = done;
        job.first.frame_ok      = good_c & ok;
        job.first.last          = 1'b1;
        crc_run_next            = CRC_INIT;
        byte_slot_next          = SLOT_HIGH;
        if (done) begin
          word_slot_next  = '0;
          assembled_next  = '0;
          frame_good_next = 1'b1;
        end else begin
          word_slot_next  = wslot_inc;
          assembled_next  = acc_shift;
          frame_good_next = good_c & ok;
        end
      end
    end else begin
      job_push            = 1'b1;
      job.first.out_byte  = req.data_byte;
      job.first.out_valid = 1'b1;
      if (slot_c == SLOT_LOW) begin
        // Second data byte: echo it, then its CRC
        low_hold_next  = req.data_byte;
        job.two        = 1'b1;
        job.crc_byte   = crc_upd;
        crc_run_next   = CRC_INIT;
        byte_slot_next = SLOT_HIGH;
      end else begin
        // First data byte; a pending decode group is dropped and the CRC restarts
        high_hold_next = req.data_byte;
        job.first.last = 1'b1;
        crc_run_next   = crc8(CRC_INIT, req.data_byte);
        byte_slot_next = SLOT_LOW;
      end
    end

    if (!accept) begin
      job_push = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_run      <= CRC_INIT;
      byte_slot    <= SLOT_HIGH;
      word_slot    <= '0;
      words_target <= TGT_W'(2);
      assembled    <= '0;
      frame_good   <= 1'b1;
    end else if (accept) begin
      crc_run      <= crc_run_next;
      byte_slot    <= byte_slot_next;
      word_slot    <= word_slot_next;
      words_target <= words_target_next;
      assembled    <= assembled_next;
      frame_good   <= frame_good_next;
    end
  end

  // Held data bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      high_hold <= high_hold_next;
      low_hold  <= low_hold_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cwfc_back.sv @@
// Output stage of the codec: drains jobs from the queue into the result
// register, handing out the two results of a two-result job in turn. Depends on cwfc_pkg.
`default_nettype none

module cwfc_back
  import cwfc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  wire job_t q_data,
  output logic      q_pop,
  input  wire logic pop,
  output logic      empty,
  output res_t      res
);

  logic       res_vld;
  logic       sec_pend;
  logic [7:0] sec_byte;
  logic       load;
  res_t       sec_res;

  assign empty = !res_vld;
  assign load  = !res_vld || pop;
  assign q_pop = load && !sec_pend && !q_empty;

  // Trailing CRC result of an encoded pair
  always_comb begin
    sec_res           = '0;
    sec_res.out_byte  = sec_byte;
    sec_res.out_valid = 1'b1;
    sec_res.last      = 1'b1;
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld  <= 1'b0;
      sec_pend <= 1'b0;
    end else if (load) begin
      if (sec_pend) begin
        res_vld  <= 1'b1;
        sec_pend <= 1'b0;
      end else if (!q_empty) begin
        res_vld  <= 1'b1;
        sec_pend <= q_data.two;
      end else begin
        res_vld  <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_pend) begin
        res <= sec_res;
      end else if (!q_empty) begin
        res      <= q_data.first;
        sec_byte <= q_data.crc_byte;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/crc8_word_frame_codec.sv @@
// CRC-8 word/frame codec (poly 0x31, init 0xFF). One byte request is taken
// per clock while the job queue has room; the front end updates the CRC and
// frame state in that same cycle. Decode bytes give a word result on every
// third byte; encode bytes give one result, or two on the second byte of a
// pair (data byte, then CRC). The result register hands out one result per
// cycle while pop keeps taking them, so a pair of encode bytes gives three
// results and the sustained rate is set by that register. A result is
// written into the job queue and then into the result register before it
// is visible. Depends on cwfc_pkg, cwfc_front, cwfc_queue, cwfc_back.
`default_nettype none

module crc8_word_frame_codec
  import cwfc_pkg::*;
#(
  parameter int unsigned QDEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire req_t req,
  output logic      empty,
  input  wire logic pop,
  output res_t      res
);

  logic accept;
  logic job_push;
  job_t job;
  logic q_empty;
  logic q_pop;
  job_t q_data;

  assign accept = push && !full;

  // Byte intake and classification
  cwfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req      (req),
    .job_push (job_push),
    .job      (job)
  );

  // Decoupling queue
  cwfc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // Result output
  cwfc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

endmodule

`default_nettype wire
